// File: design/irs_pkg.sv
// shared types, constants and helper functions of the image resize interpolator
`timescale 1ns / 1ps
`default_nettype none
package irs_pkg;

	localparam int unsigned MAX_WIDTH_DEF    = 64;
	localparam int unsigned MAX_HEIGHT_DEF   = 64;
	localparam int unsigned MAX_CHANNELS_DEF = 4;

	localparam int unsigned IDX_W      = 12;
	localparam int unsigned CH_W       = 2;
	localparam int unsigned SAMPLE_W   = 16;
	localparam int unsigned SIZE_W     = 7;
	localparam int unsigned DST_W      = 13;
	localparam int unsigned CNT_W      = 3;
	localparam int unsigned CRD_W      = 7;
	localparam int unsigned FRAC_W     = 16;
	localparam int unsigned RATIO_W    = SIZE_W + FRAC_W;
	localparam int unsigned PROD_W     = RATIO_W + IDX_W;
	localparam int unsigned PX_W       = PROD_W + 2;
	localparam int unsigned FLR_W      = PX_W - FRAC_W;
	localparam int unsigned WGT_W      = FRAC_W + 1;
	localparam int unsigned TERM_W     = 32;
	localparam int unsigned ACC_W      = 48;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 13;
	localparam int unsigned Q_DEPTH    = 4;

	localparam logic [WGT_W-1:0] W_ONE    = WGT_W'(1) << FRAC_W;
	localparam logic [PX_W-1:0]  PX_HALF  = PX_W'(1) << (FRAC_W - 1);
	localparam logic [ACC_W-1:0] ACC_HALF = ACC_W'(1) << (2 * FRAC_W - 1);

	localparam logic ACT_WRITE   = 1'b0;
	localparam logic ACT_REQUEST = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SRC_WIDTH     = 3'd0,
		CFG_SRC_HEIGHT    = 3'd1,
		CFG_DST_WIDTH     = 3'd2,
		CFG_DST_HEIGHT    = 3'd3,
		CFG_CHANNEL_COUNT = 3'd4,
		CFG_INTERP_MODE   = 3'd5
	} cfg_idx_t;

	localparam logic [SIZE_W-1:0] RST_SRC_WIDTH     = 7'd64;
	localparam logic [SIZE_W-1:0] RST_SRC_HEIGHT    = 7'd64;
	localparam logic [DST_W-1:0]  RST_DST_WIDTH     = 13'd64;
	localparam logic [DST_W-1:0]  RST_DST_HEIGHT    = 13'd64;
	localparam logic [CNT_W-1:0]  RST_CHANNEL_COUNT = 3'd3;
	localparam logic              RST_INTERP_MODE   = 1'b1;

	typedef enum logic [1:0] {
		K_WRITE = 2'd0,
		K_ZERO  = 2'd1,
		K_NEAR  = 2'd2,
		K_BILIN = 2'd3
	} kind_t;

	typedef struct packed {
		logic [SIZE_W-1:0] src_width;
		logic [SIZE_W-1:0] src_height;
		logic [DST_W-1:0]  dst_width;
		logic [DST_W-1:0]  dst_height;
		logic [CNT_W-1:0]  channel_count;
		logic              interp_mode;
	} cfg_t;

	typedef struct packed {
		logic [SIZE_W-1:0]  sw;
		logic [SIZE_W-1:0]  sh;
		logic [CNT_W-1:0]   cc;
		logic               bilinear;
		logic [RATIO_W-1:0] ratio_x;
		logic [RATIO_W-1:0] ratio_y;
	} front_cfg_t;

	typedef struct packed {
		kind_t               kind;
		logic [CRD_W-1:0]    c0;
		logic [CRD_W-1:0]    c1;
		logic [CRD_W-1:0]    r0;
		logic [CRD_W-1:0]    r1;
		logic [FRAC_W-1:0]   fx;
		logic [FRAC_W-1:0]   fy;
		logic [CH_W-1:0]     ch;
		logic [SAMPLE_W-1:0] sample;
	} q_entry_t;

	typedef struct packed {
		logic             valid;
		logic             first;
		logic             last;
		logic             zero;
		logic [WGT_W-1:0] wx;
		logic [WGT_W-1:0] wy;
	} bctl_t;

	function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
		input int unsigned maxv);
		if (v == '0) return SIZE_W'(1);
		if (32'(v) > maxv) return SIZE_W'(maxv);
		return v;
	endfunction

	function automatic logic [CNT_W-1:0] eff_chan(input logic [CNT_W-1:0] v,
		input int unsigned maxv);
		if (v == '0) return CNT_W'(1);
		if (32'(v) > maxv) return CNT_W'(maxv);
		return v;
	endfunction

	function automatic logic [CRD_W-1:0] clamp_crd(input logic signed [FLR_W-1:0] v,
		input logic [SIZE_W-1:0] n);
		if (v < 0) return '0;
		if (v >= $signed({{(FLR_W-SIZE_W){1'b0}}, n})) return CRD_W'(n - SIZE_W'(1));
		return v[CRD_W-1:0];
	endfunction

endpackage
`default_nettype wire

// File: design/irs_if.sv
// item channel and configuration channel interfaces
`timescale 1ns / 1ps
`default_nettype none
interface irs_in_if;
	logic                          valid;
	logic                          ready;
	logic                          action;
	logic [irs_pkg::IDX_W-1:0]    col_index;
	logic [irs_pkg::IDX_W-1:0]    row_index;
	logic [irs_pkg::CH_W-1:0]     channel;
	logic [irs_pkg::SAMPLE_W-1:0] sample_in;
	modport source (output valid, action, col_index, row_index, channel, sample_in,
		input ready);
	modport sink (input valid, action, col_index, row_index, channel, sample_in,
		output ready);
endinterface

interface irs_out_if;
	logic                          valid;
	logic                          ready;
	logic [irs_pkg::SAMPLE_W-1:0] sample_out;
	modport source (output valid, sample_out, input ready);
	modport sink (input valid, sample_out, output ready);
endinterface

interface irs_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [irs_pkg::CFG_IDX_W-1:0]  index;
	logic [irs_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: design/irs_div.sv
// bit-serial restoring divider for the scale ratio
`timescale 1ns / 1ps
`default_nettype none
module irs_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [irs_pkg::RATIO_W-1:0]   dividend,
	input  wire logic [irs_pkg::DST_W-1:0]     divisor,
	output logic                               busy,
	output logic [irs_pkg::RATIO_W-1:0]        quotient
);
	import irs_pkg::*;

	localparam int unsigned STEP_W = $clog2(RATIO_W + 1);

	logic                 busy_q;
	logic [STEP_W-1:0]    step_q;
	logic [DST_W-1:0]     rem_q;
	logic [DST_W-1:0]     divr_q;
	logic [RATIO_W-1:0]   quo_q;
	logic [DST_W:0]       trial;
	logic                 ge;
	logic [DST_W-1:0]     rem_nx;

	always_comb begin
		trial  = {rem_q, quo_q[RATIO_W-1]};
		ge     = trial >= {1'b0, divr_q};
		rem_nx = ge ? DST_W'(trial - {1'b0, divr_q}) : trial[DST_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= STEP_W'(RATIO_W);
		end else if (busy_q) begin
			step_q <= step_q - STEP_W'(1);
			if (step_q == STEP_W'(1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quo_q  <= dividend;
			divr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			quo_q <= {quo_q[RATIO_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;
endmodule
`default_nettype wire

// File: design/irs_ram.sv
// generic single-write single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none
module irs_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 16384
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: design/irs_queue.sv
// short item queue between the front and back parts
`timescale 1ns / 1ps
`default_nettype none
module irs_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire irs_pkg::q_entry_t  din,
	output logic                    full,
	input  wire logic               pop,
	output irs_pkg::q_entry_t       dout,
	output logic                    empty
);
	import irs_pkg::*;

	localparam int unsigned PTR_W = $clog2(Q_DEPTH);
	localparam int unsigned LVL_W = $clog2(Q_DEPTH + 1);

	q_entry_t         slots [Q_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [LVL_W-1:0] lvl_q;

	assign full  = lvl_q == LVL_W'(Q_DEPTH);
	assign empty = lvl_q == '0;
	assign dout  = slots[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			lvl_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			if (pop) rd_q <= (rd_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			if (push && !pop) lvl_q <= lvl_q + LVL_W'(1);
			else if (pop && !push) lvl_q <= lvl_q - LVL_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) slots[wr_q] <= din;
	end
endmodule
`default_nettype wire

// File: design/irs_front.sv
// front part: accepts items, classifies them and maps request coordinates
`timescale 1ns / 1ps
`default_nettype none
module irs_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	irs_in_if.sink                    req,
	input  wire irs_pkg::front_cfg_t  fcfg,
	input  wire logic                 hold,
	input  wire logic                 full,
	output logic                      push,
	output irs_pkg::q_entry_t         entry
);
	import irs_pkg::*;

	logic                 accept, wr_ok, is_write, keep_in, en2, ld1;
	kind_t                kind_in;

	logic                 v1_q;
	kind_t                kind_s1;
	logic [CRD_W-1:0]     col_s1, row_s1;
	logic [CH_W-1:0]      ch_s1;
	logic [SAMPLE_W-1:0]  sample_s1;
	logic [PROD_W-1:0]    prodx_s1, prody_s1;

	logic                 v2_q;
	q_entry_t             entry_s2;
	q_entry_t             nx;

	logic signed [PX_W-1:0]  px, py, pxr, pyr;
	logic signed [FLR_W-1:0] xl, yt, xn, yn;

	assign en2    = !v2_q || !full;
	assign ld1    = !v1_q || en2;
	assign req.ready = !hold && ld1;
	assign accept = req.valid && req.ready;
	assign push   = v2_q && !full;
	assign entry  = entry_s2;

	always_comb begin
		is_write = req.action == ACT_WRITE;
		wr_ok = (req.col_index < {{(IDX_W-SIZE_W){1'b0}}, fcfg.sw})
			&& (req.row_index < {{(IDX_W-SIZE_W){1'b0}}, fcfg.sh})
			&& ({1'b0, req.channel} < fcfg.cc);
		keep_in = !is_write || wr_ok;
		if (is_write) kind_in = K_WRITE;
		else if ({1'b0, req.channel} >= fcfg.cc) kind_in = K_ZERO;
		else if (fcfg.bilinear) kind_in = K_BILIN;
		else kind_in = K_NEAR;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
		end else begin
			if (ld1) v1_q <= accept && keep_in;
			if (en2) v2_q <= v1_q;
		end
	end

	// stage 1: register the item and the ratio*index products
	always_ff @(posedge clk) begin
		if (ld1) begin
			kind_s1   <= kind_in;
			col_s1    <= req.col_index[CRD_W-1:0];
			row_s1    <= req.row_index[CRD_W-1:0];
			ch_s1     <= req.channel;
			sample_s1 <= req.sample_in;
			prodx_s1  <= PROD_W'(fcfg.ratio_x) * PROD_W'(req.col_index);
			prody_s1  <= PROD_W'(fcfg.ratio_y) * PROD_W'(req.row_index);
		end
	end

	// stage 2: offset by half a ratio minus half a pixel, floor or round, clamp
	always_comb begin
		px  = $signed({2'b00, prodx_s1}) + $signed({{(PX_W-RATIO_W+1){1'b0}},
			fcfg.ratio_x[RATIO_W-1:1]}) - $signed(PX_HALF);
		py  = $signed({2'b00, prody_s1}) + $signed({{(PX_W-RATIO_W+1){1'b0}},
			fcfg.ratio_y[RATIO_W-1:1]}) - $signed(PX_HALF);
		pxr = px + $signed(PX_HALF);
		pyr = py + $signed(PX_HALF);
		xl  = px[PX_W-1:FRAC_W];
		yt  = py[PX_W-1:FRAC_W];
		xn  = pxr[PX_W-1:FRAC_W];
		yn  = pyr[PX_W-1:FRAC_W];

		nx.kind   = kind_s1;
		nx.ch     = ch_s1;
		nx.sample = sample_s1;
		nx.fx     = px[FRAC_W-1:0];
		nx.fy     = py[FRAC_W-1:0];
		nx.c1     = clamp_crd(xl + FLR_W'(1), fcfg.sw);
		nx.r1     = clamp_crd(yt + FLR_W'(1), fcfg.sh);
		case (kind_s1)
			K_WRITE: begin
				nx.c0 = col_s1;
				nx.r0 = row_s1;
			end
			K_NEAR: begin
				nx.c0 = clamp_crd(xn, fcfg.sw);
				nx.r0 = clamp_crd(yn, fcfg.sh);
			end
			default: begin
				nx.c0 = clamp_crd(xl, fcfg.sw);
				nx.r0 = clamp_crd(yt, fcfg.sh);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en2) entry_s2 <= nx;
	end
endmodule
`default_nettype wire

// File: design/irs_back.sv
// back part: frame store access, weighting and accumulation of results
`timescale 1ns / 1ps
`default_nettype none
module irs_back #(
	parameter int unsigned MAX_WIDTH    = irs_pkg::MAX_WIDTH_DEF,
	parameter int unsigned MAX_HEIGHT   = irs_pkg::MAX_HEIGHT_DEF,
	parameter int unsigned MAX_CHANNELS = irs_pkg::MAX_CHANNELS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire irs_pkg::q_entry_t   head,
	input  wire logic                head_valid,
	output logic                     pop,
	irs_out_if.source                rsp
);
	import irs_pkg::*;

	localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS;
	localparam int unsigned AW    = $clog2(DEPTH);

	logic                pipe_en, issue, last_ph, we;
	logic [1:0]          ph_q;
	logic [CRD_W-1:0]    sel_c, sel_r;
	logic [31:0]         addr_wide;
	logic [AW-1:0]       addr;
	bctl_t               ctl_in, ctl_s1, ctl_s2, ctl_s3;
	logic [SAMPLE_W-1:0] rd_data;
	logic [TERM_W-1:0]   pa_s2;
	logic [ACC_W-1:0]    pb_s3, acc_q, acc_sum, acc_rnd;
	logic                rsp_valid_q;
	logic [SAMPLE_W-1:0] rsp_data_q;

	assign pipe_en = !rsp_valid_q || rsp.ready;
	assign issue   = pipe_en && head_valid;
	assign last_ph = (head.kind != K_BILIN) || (ph_q == 2'd3);
	assign pop     = issue && last_ph;
	assign we      = issue && (head.kind == K_WRITE);

	// phase bit 0 picks the right column, bit 1 the bottom row
	always_comb begin
		sel_c     = ph_q[0] ? head.c1 : head.c0;
		sel_r     = ph_q[1] ? head.r1 : head.r0;
		addr_wide = (32'(sel_r) * 32'(MAX_WIDTH) + 32'(sel_c)) * 32'(MAX_CHANNELS)
			+ 32'(head.ch);
		addr      = addr_wide[AW-1:0];

		ctl_in.valid = issue && (head.kind != K_WRITE);
		ctl_in.first = ph_q == 2'd0;
		ctl_in.last  = last_ph;
		ctl_in.zero  = head.kind == K_ZERO;
		if (head.kind == K_BILIN) begin
			ctl_in.wx = ph_q[0] ? {1'b0, head.fx} : W_ONE - {1'b0, head.fx};
			ctl_in.wy = ph_q[1] ? {1'b0, head.fy} : W_ONE - {1'b0, head.fy};
		end else begin
			ctl_in.wx = W_ONE;
			ctl_in.wy = W_ONE;
		end
	end

	irs_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(addr),
		.wdata(head.sample),
		.re   (pipe_en),
		.raddr(addr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q        <= '0;
			ctl_s1      <= '0;
			ctl_s2      <= '0;
			ctl_s3      <= '0;
			rsp_valid_q <= 1'b0;
		end else if (pipe_en) begin
			if (pop) ph_q <= '0;
			else if (issue) ph_q <= ph_q + 2'd1;
			ctl_s1      <= ctl_in;
			ctl_s2      <= ctl_s1;
			ctl_s3      <= ctl_s2;
			rsp_valid_q <= ctl_s3.valid && ctl_s3.last;
		end
	end

	always_comb begin
		acc_sum = (ctl_s3.first ? '0 : acc_q) + pb_s3;
		acc_rnd = acc_sum + ACC_HALF;
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			pa_s2 <= ctl_s1.zero ? '0 : TERM_W'(rd_data) * TERM_W'(ctl_s1.wx);
			pb_s3 <= ACC_W'(pa_s2) * ACC_W'(ctl_s2.wy);
			if (ctl_s3.valid) begin
				acc_q      <= acc_sum;
				rsp_data_q <= acc_rnd[2*FRAC_W +: SAMPLE_W];
			end
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.sample_out = rsp_data_q;
endmodule
`default_nettype wire

// File: design/image_resize_interpolator.sv
// top level of the image resize interpolator
//
// Source samples are written into an internal frame store (one memory of
// MAX_WIDTH*MAX_HEIGHT*MAX_CHANNELS 16-bit entries, addressed
// (row*MAX_WIDTH + col)*MAX_CHANNELS + channel) with action 0; a request
// (action 1) maps a destination column and row to a signed Q21.16 source
// position, ratio*index + ratio/2 - 1/2, and returns either the nearest sample
// or a bilinear blend of four neighbors, clamped to the image edge. Writes
// outside the source size or channel count are dropped silently; a request for
// a channel beyond the count returns zero. Every sample must be written before
// it is read. The front accepts one item per cycle unless the divider or a full
// queue holds it off, two register stages do the mapping, and a four-entry
// queue feeds the back, which owns the single frame store read port: a bilinear
// request reads its four neighbors there one after another, while a nearest
// request, a zero result or a write uses the port once. The back issues the
// next read while earlier ones are still in its pipeline; a result passes the
// front stages, the queue, the frame store read, the weighting by wx and then
// by wy, and the result register. After reset and after every write of a
// source or destination size, the scale ratios are recomputed by a bit-serial
// divider, and req.ready stays low until it is done. The configuration port
// never stalls and must only be written while no item is in flight.
`timescale 1ns / 1ps
`default_nettype none
module image_resize_interpolator #(
	parameter int unsigned MAX_WIDTH    = irs_pkg::MAX_WIDTH_DEF,
	parameter int unsigned MAX_HEIGHT   = irs_pkg::MAX_HEIGHT_DEF,
	parameter int unsigned MAX_CHANNELS = irs_pkg::MAX_CHANNELS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	irs_cfg_if.sink   cfg,
	irs_in_if.sink    req,
	irs_out_if.source rsp
);
	import irs_pkg::*;

	cfg_t               cfg_q;
	logic               start_q;
	logic               cfg_we;
	logic [SIZE_W-1:0]  sw, sh;
	logic [DST_W-1:0]   dw, dh;
	logic [RATIO_W-1:0] ratio_x, ratio_y;
	logic               busy_x, busy_y, div_busy;
	front_cfg_t         fcfg;
	q_entry_t           q_in, q_out;
	logic               q_push, q_pop, q_full, q_empty;

	// config port: always ready, registers held in one struct
	assign cfg.ready = 1'b1;
	assign cfg_we    = cfg.valid && cfg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.src_width     <= RST_SRC_WIDTH;
			cfg_q.src_height    <= RST_SRC_HEIGHT;
			cfg_q.dst_width     <= RST_DST_WIDTH;
			cfg_q.dst_height    <= RST_DST_HEIGHT;
			cfg_q.channel_count <= RST_CHANNEL_COUNT;
			cfg_q.interp_mode   <= RST_INTERP_MODE;
			start_q             <= 1'b1;
		end else begin
			start_q <= 1'b0;
			if (cfg_we) begin
				case (cfg.index)
					CFG_SRC_WIDTH: begin
						cfg_q.src_width <= cfg.data[SIZE_W-1:0];
						start_q         <= 1'b1;
					end
					CFG_SRC_HEIGHT: begin
						cfg_q.src_height <= cfg.data[SIZE_W-1:0];
						start_q          <= 1'b1;
					end
					CFG_DST_WIDTH: begin
						cfg_q.dst_width <= cfg.data;
						start_q         <= 1'b1;
					end
					CFG_DST_HEIGHT: begin
						cfg_q.dst_height <= cfg.data;
						start_q          <= 1'b1;
					end
					CFG_CHANNEL_COUNT: begin
						cfg_q.channel_count <= cfg.data[CNT_W-1:0];
					end
					CFG_INTERP_MODE: begin
						cfg_q.interp_mode <= cfg.data[0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	// effective sizes: zero reads as one, source sizes saturate at the store size
	always_comb begin
		sw = eff_size(cfg_q.src_width, MAX_WIDTH);
		sh = eff_size(cfg_q.src_height, MAX_HEIGHT);
		dw = (cfg_q.dst_width == '0) ? DST_W'(1) : cfg_q.dst_width;
		dh = (cfg_q.dst_height == '0) ? DST_W'(1) : cfg_q.dst_height;
	end

	// ratio = floor(src * 2^16 / dst), one quotient bit per cycle
	irs_div u_div_x (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start_q),
		.dividend({sw, {FRAC_W{1'b0}}}),
		.divisor (dw),
		.busy    (busy_x),
		.quotient(ratio_x)
	);

	irs_div u_div_y (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start_q),
		.dividend({sh, {FRAC_W{1'b0}}}),
		.divisor (dh),
		.busy    (busy_y),
		.quotient(ratio_y)
	);

	assign div_busy = start_q || busy_x || busy_y;

	always_comb begin
		fcfg.sw       = sw;
		fcfg.sh       = sh;
		fcfg.cc       = eff_chan(cfg_q.channel_count, MAX_CHANNELS);
		fcfg.bilinear = cfg_q.interp_mode;
		fcfg.ratio_x  = ratio_x;
		fcfg.ratio_y  = ratio_y;
	end

	irs_front u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.fcfg  (fcfg),
		.hold  (div_busy),
		.full  (q_full),
		.push  (q_push),
		.entry (q_in)
	);

	irs_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.din   (q_in),
		.full  (q_full),
		.pop   (q_pop),
		.dout  (q_out),
		.empty (q_empty)
	);

	irs_back #(
		.MAX_WIDTH   (MAX_WIDTH),
		.MAX_HEIGHT  (MAX_HEIGHT),
		.MAX_CHANNELS(MAX_CHANNELS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_out),
		.head_valid(!q_empty),
		.pop       (q_pop),
		.rsp       (rsp)
	);
endmodule
`default_nettype wire

// File: design/irs_checker.sv
// port-level checker of the image resize interpolator and its bind
`timescale 1ns / 1ps
`default_nettype none
module irs_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           cfg_valid,
	input wire logic                           cfg_ready,
	input wire logic [irs_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic                           req_ready,
	input wire logic                           rsp_valid,
	input wire logic                           rsp_ready,
	input wire logic [irs_pkg::SAMPLE_W-1:0]  rsp_sample_out
);
	import irs_pkg::*;

	// a stalled result stays put
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_out))
		else $error("result dropped or changed while stalled");

	// a size write restarts the ratio divider, so items are held off
	a_size_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready && (cfg_index == CFG_SRC_WIDTH
		|| cfg_index == CFG_SRC_HEIGHT || cfg_index == CFG_DST_WIDTH
		|| cfg_index == CFG_DST_HEIGHT) |=> !req_ready)
		else $error("item port open while ratio recomputes");

	// register writes are never back-pressured
	a_cfg_open: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("config port stalled");
endmodule

bind image_resize_interpolator irs_checker u_irs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cfg_valid     (cfg.valid),
	.cfg_ready     (cfg.ready),
	.cfg_index     (cfg.index),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_sample_out(rsp.sample_out)
);
`default_nettype wire
